// ===== src/fdl_pkg.sv =====
// Shared constants and types of the fractional delay line.
package fdl_pkg;

  // Number of stored samples.
  localparam int DEPTH = 1024;
  // Store address width.
  localparam int AW = $clog2(DEPTH);
  // Delay and read position, Q(AW).16 in samples.
  localparam int CD_W = AW + 16;

  localparam int SAMPLE_W = 16;
  localparam int TARGET_W = 18;
  localparam int COEF_W = 16;
  localparam int CFG_IDX_W = 1;

  // Target in Q.16 is the Q10.8 register shifted by eight.
  localparam int TQ_W = TARGET_W + 8;
  localparam int CMP_W = (CD_W > TQ_W) ? CD_W : TQ_W;

  localparam logic [CMP_W-1:0] TGT_LO_Q16 = CMP_W'(longint'(1) << 16);
  localparam logic [CMP_W-1:0] TGT_HI_Q16 = CMP_W'(longint'(DEPTH - 2) << 16);
  localparam logic [CD_W:0] SPAN = (CD_W + 1)'(longint'(DEPTH) << 16);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Register indices on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TARGET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 1'd1;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 18'd256;
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd66;

  // Head of the input queue as seen by the engine.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
  } fdl_item_t;

endpackage

// ===== src/fdl_queue.sv =====
// Two-entry input queue between the slave channel and the delay engine.
module fdl_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fdl_pkg::SAMPLE_W-1:0] in_sample,
  output fdl_pkg::fdl_item_t           head,
  input  logic                         pop
);

  logic [fdl_pkg::SAMPLE_W-1:0] slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       take;

  assign in_ready    = (count_r != 2'd2);
  assign push        = in_valid && in_ready;
  assign take        = pop && (count_r != 2'd0);
  assign head.valid  = (count_r != 2'd0);
  assign head.sample = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, take})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/fdl_engine.sv =====
// Delay engine: sample store, read position, smoothing and interpolation.
module fdl_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fdl_pkg::fdl_item_t            head,
  output logic                          pop,
  input  logic                          cfg_we,
  input  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdl_pkg::TARGET_W-1:0]  cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdl_pkg::SAMPLE_W-1:0]  out_sample
);

  localparam int AW = fdl_pkg::AW;
  localparam int CD_W = fdl_pkg::CD_W;
  localparam int CMP_W = fdl_pkg::CMP_W;
  localparam int SW = fdl_pkg::SAMPLE_W;

  logic [SW-1:0]               store_r [fdl_pkg::DEPTH];
  logic [AW-1:0]               wp_r;
  logic                        full_r;
  logic [CD_W-1:0]             cd_r;
  logic [fdl_pkg::TARGET_W-1:0] target_r;
  logic [fdl_pkg::COEF_W-1:0]  coef_r;
  logic                        phase_r;
  logic [15:0]                 frac_r;
  logic                        v0_r;
  logic                        v1_r;
  logic [SW-1:0]               rd0_r;
  logic [SW-1:0]               rd1_r;
  logic [CD_W-1:0]             mag_r;
  logic                        down_r;
  logic                        out_valid_r;
  logic [SW-1:0]               out_data_r;

  logic [CD_W-1:0]    wp_q16;
  logic [CD_W-1:0]    pos;
  logic [AW-1:0]      i0;
  logic [AW-1:0]      i1;
  logic [CMP_W-1:0]   tq;
  logic [CD_W-1:0]    tgt;
  logic [CD_W-1:0]    diff;
  logic               down_nxt;
  logic [CD_W+15:0]   sm_prod;
  logic [CD_W-1:0]    cd_nxt;
  logic               finish;
  logic [SW-1:0]      s0;
  logic [SW-1:0]      s1;
  logic signed [16:0] d;
  logic signed [33:0] ip;
  logic signed [33:0] ip_biased;
  logic [SW-1:0]      y_nxt;

  assign pop    = !phase_r && head.valid;
  assign finish = phase_r && (!out_valid_r || out_ready);

  // Read position is the write position minus the delay, wrapped into the store.
  always_comb begin
    wp_q16 = {wp_r, 16'b0};
    if (wp_q16 >= cd_r) begin
      pos = wp_q16 - cd_r;
    end else begin
      pos = CD_W'({1'b0, wp_q16} + fdl_pkg::SPAN - {1'b0, cd_r});
    end
    i0 = pos[CD_W-1:16];
    i1 = (i0 == fdl_pkg::LAST_ADDR) ? '0 : i0 + 1'b1;
  end

  // One smoothing step toward the clamped target; the product is registered.
  always_comb begin
    tq = CMP_W'({target_r, 8'b0});
    if (tq < fdl_pkg::TGT_LO_Q16) begin
      tq = fdl_pkg::TGT_LO_Q16;
    end else if (tq > fdl_pkg::TGT_HI_Q16) begin
      tq = fdl_pkg::TGT_HI_Q16;
    end
    tgt = tq[CD_W-1:0];
    if (tgt >= cd_r) begin
      diff     = tgt - cd_r;
      down_nxt = 1'b0;
    end else begin
      diff     = cd_r - tgt;
      down_nxt = 1'b1;
    end
    sm_prod = (CD_W + 16)'(diff) * (CD_W + 16)'(coef_r);
    cd_nxt  = down_r ? cd_r - mag_r : cd_r + mag_r;
  end

  // Entries not yet written since reset read as zero.
  always_comb begin
    s0        = v0_r ? rd0_r : '0;
    s1        = v1_r ? rd1_r : '0;
    d         = $signed({s1[SW-1], s1}) - $signed({s0[SW-1], s0});
    ip        = d * $signed({1'b0, frac_r});
    ip_biased = ip + (ip[33] ? 34'sd65535 : 34'sd0);
    y_nxt     = s0 + SW'(ip_biased >>> 16);
  end

  // The new sample is written in the same cycle as both reads, which see the old contents.
  always_ff @(posedge clk) begin
    if (pop) begin
      store_r[wp_r] <= head.sample;
      rd0_r         <= store_r[i0];
      rd1_r         <= store_r[i1];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frac_r <= pos[15:0];
      v0_r   <= full_r || (i0 < wp_r);
      v1_r   <= full_r || (i1 < wp_r);
      mag_r  <= sm_prod[CD_W+15:16];
      down_r <= down_nxt;
    end
    if (finish) begin
      out_data_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      full_r      <= 1'b0;
      cd_r        <= '0;
      target_r    <= fdl_pkg::TARGET_RESET;
      coef_r      <= fdl_pkg::COEF_RESET;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fdl_pkg::REG_DELAY_TARGET: target_r <= cfg_wdata;
          fdl_pkg::REG_SMOOTHING:    coef_r   <= cfg_wdata[fdl_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        phase_r <= 1'b1;
        if (wp_r == fdl_pkg::LAST_ADDR) begin
          wp_r   <= '0;
          full_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
      if (finish) begin
        phase_r     <= 1'b0;
        cd_r        <= cd_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;

endmodule

// ===== src/fractional_delay_line.sv =====
// Top level of the fractional delay line with linear interpolation.
// Usage:
//   Samples (Q1.15) arrive on the in_ stream channel; each request gives
//   exactly one delayed, interpolated sample on the out_ stream channel,
//   in order. The delay follows delay_target (Q10.8 samples, clamped to
//   1 .. DEPTH-2) through a one-pole smoother set by smoothing_coefficient.
//   User writes registers on cfg_ port only with the block idle; unchecked.
// Timing:
//   A request taken into an empty block passes the store read registers
//   and then the output register. A new sample is taken only after the
//   last has finished: the store is read at two addresses and written
//   together, and the registered smoothing product then updates the delay.
// Reset:
//   The delay goes to zero, the write position to the first entry and the
//   registers to their reset values. Store entries not written since reset
//   read as zero through a fill marker, so there is no clearing pass.
// Back-pressure:
//   A two-entry input queue keeps taking requests, until it is full,
//   while a finished result waits in the output register for out_tready.
module fractional_delay_line (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [15:0] delayed_sample
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [17:0] cfg_wdata
);

  fdl_pkg::fdl_item_t head;
  logic               pop;

  fdl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  fdl_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata)
  );

endmodule
